/* rtl/core/ils_pkg.sv */
package ils_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    K_READ      = 3'd0,
    K_INS_FRONT = 3'd1,
    K_INS_BACK  = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_AT    = 3'd4,
    K_SWAP      = 3'd5,
    K_DUMP      = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_SAME      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SWP_A,
    S_SWP_B,
    S_SWP_WB,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [3:0]                index_a;
    logic [3:0]                index_b;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                out_index;
    logic signed [DATA_W-1:0]  out_value;
    status_t                   status;
    logic                      last;
    logic [4:0]                length;
  } out_item_t;

endpackage

/* rtl/core/indexed_list_store.sv */
// Ordered store of up to DEPTH signed 32-bit values held packed in a single-port-write,
// single-port-read memory with a registered read. One request is worked on at a time and
// in_stall stays high until its last result has been loaded into the output register.
// Read, error and insert-back requests go straight to the response; swap reads both
// entries and writes them back crossed; insert front and delete shift the entries one
// place at a time, and dump reads and hands out each entry in turn. Each shift step of an
// insert or delete is one memory read followed by one memory write. The memory needs no
// clearing after reset.
module indexed_list_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ils_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ils_pkg::out_item_t  out_data
);

  localparam int IW = ils_pkg::IDX_W;
  localparam int CW = ils_pkg::CNT_W;
  localparam int DW = ils_pkg::DATA_W;

  logic [DW-1:0] mem [ils_pkg::DEPTH];

  ils_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;
  ils_pkg::kind_t     op_r, op_nxt;
  logic [IW-1:0]      ia_r, ia_nxt;
  logic [IW-1:0]      ib_r, ib_nxt;
  logic [DW-1:0]      val_r, val_nxt;
  logic [DW-1:0]      tmp_r, tmp_nxt;
  logic [IW-1:0]      res_index_r, res_index_nxt;
  ils_pkg::status_t   res_status_r, res_status_nxt;
  logic [DW-1:0]      rdata_r;
  logic               out_valid_r, out_valid_nxt;
  ils_pkg::out_item_t out_data_r, out_data_nxt;

  logic               accept;
  logic               out_free;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [DW-1:0]      mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic               out_load;
  ils_pkg::status_t   req_status;
  logic               is_empty;
  logic               is_full;
  logic               a_bad;
  logic               b_bad;
  logic               del_more;
  logic               dump_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ils_pkg::S_IDLE);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r >= CW'(ils_pkg::DEPTH));
  assign a_bad     = ({1'b0, in_data.index_a} >= cnt_r);
  assign b_bad     = ({1'b0, in_data.index_b} >= cnt_r);
  assign del_more  = ((CW'(ptr_r) + CW'(1)) < cnt_r);
  assign dump_last = ((CW'(ptr_r) + CW'(1)) == cnt_r);

  // Outcome of a new request, decided from the count and the indices before any memory work.
  always_comb begin
    unique case (in_data.kind)
      ils_pkg::K_READ, ils_pkg::K_DEL_AT: begin
        priority if (is_empty) req_status = ils_pkg::ST_EMPTY;
        else if (a_bad)        req_status = ils_pkg::ST_BAD_INDEX;
        else                   req_status = ils_pkg::ST_OK;
      end
      ils_pkg::K_INS_FRONT, ils_pkg::K_INS_BACK: begin
        req_status = is_full ? ils_pkg::ST_FULL : ils_pkg::ST_OK;
      end
      ils_pkg::K_DEL_FRONT, ils_pkg::K_DUMP: begin
        req_status = is_empty ? ils_pkg::ST_EMPTY : ils_pkg::ST_OK;
      end
      ils_pkg::K_SWAP: begin
        priority if (is_empty)                  req_status = ils_pkg::ST_EMPTY;
        else if (a_bad || b_bad)                req_status = ils_pkg::ST_BAD_INDEX;
        else if (in_data.index_a == in_data.index_b) req_status = ils_pkg::ST_SAME;
        else                                    req_status = ils_pkg::ST_OK;
      end
      default: req_status = ils_pkg::ST_BAD_INDEX;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ils_pkg::S_IDLE: begin
        if (accept) begin
          if (req_status != ils_pkg::ST_OK) begin
            state_nxt = ils_pkg::S_RESP;
          end else begin
            unique case (in_data.kind)
              ils_pkg::K_INS_FRONT:                 state_nxt = ils_pkg::S_INS_RD;
              ils_pkg::K_DEL_FRONT, ils_pkg::K_DEL_AT: state_nxt = ils_pkg::S_DEL_RD;
              ils_pkg::K_SWAP:                      state_nxt = ils_pkg::S_SWP_A;
              ils_pkg::K_DUMP:                      state_nxt = ils_pkg::S_DUMP_RD;
              default:                              state_nxt = ils_pkg::S_RESP;
            endcase
          end
        end
      end
      ils_pkg::S_RESP:     if (out_free) state_nxt = ils_pkg::S_IDLE;
      ils_pkg::S_INS_RD:   state_nxt = (ptr_r == '0) ? ils_pkg::S_RESP : ils_pkg::S_INS_WR;
      ils_pkg::S_INS_WR:   state_nxt = ils_pkg::S_INS_RD;
      ils_pkg::S_DEL_RD:   state_nxt = del_more ? ils_pkg::S_DEL_WR : ils_pkg::S_RESP;
      ils_pkg::S_DEL_WR:   state_nxt = ils_pkg::S_DEL_RD;
      ils_pkg::S_SWP_A:    state_nxt = ils_pkg::S_SWP_B;
      ils_pkg::S_SWP_B:    state_nxt = ils_pkg::S_SWP_WB;
      ils_pkg::S_SWP_WB:   state_nxt = ils_pkg::S_RESP;
      ils_pkg::S_DUMP_RD:  state_nxt = ils_pkg::S_DUMP_OUT;
      ils_pkg::S_DUMP_OUT: begin
        if (out_free) state_nxt = dump_last ? ils_pkg::S_IDLE : ils_pkg::S_DUMP_RD;
      end
      default:             state_nxt = ils_pkg::S_IDLE;
    endcase
  end

  // Memory control, working registers and the output register.
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = rdata_r;
    mem_raddr      = ia_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    op_nxt         = op_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    val_nxt        = val_r;
    tmp_nxt        = tmp_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;

    unique case (state_r)
      ils_pkg::S_IDLE: begin
        mem_raddr = in_data.index_a;
        if (accept) begin
          op_nxt         = in_data.kind;
          ia_nxt         = in_data.index_a;
          ib_nxt         = in_data.index_b;
          val_nxt        = in_data.value;
          res_status_nxt = req_status;
          res_index_nxt  = '0;
          ptr_nxt        = '0;
          if (req_status == ils_pkg::ST_OK) begin
            unique case (in_data.kind)
              ils_pkg::K_READ, ils_pkg::K_DEL_AT, ils_pkg::K_SWAP: begin
                res_index_nxt = in_data.index_a;
                ptr_nxt       = in_data.index_a;
              end
              ils_pkg::K_INS_FRONT: ptr_nxt = cnt_r[IW-1:0];
              ils_pkg::K_INS_BACK: begin
                mem_we        = 1'b1;
                mem_waddr     = cnt_r[IW-1:0];
                mem_wdata     = in_data.value;
                cnt_nxt       = cnt_r + CW'(1);
                res_index_nxt = cnt_r[IW-1:0];
              end
              default: ptr_nxt = '0;
            endcase
          end
        end
      end
      ils_pkg::S_RESP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_data_nxt.out_index = res_index_r;
          out_data_nxt.out_value = (op_r == ils_pkg::K_READ && res_status_r == ils_pkg::ST_OK)
                                   ? rdata_r : '0;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.last      = 1'b1;
          out_data_nxt.length    = cnt_r;
        end
      end
      ils_pkg::S_INS_RD: begin
        mem_raddr = ptr_r - IW'(1);
        if (ptr_r == '0) begin
          // Every older entry has moved up; the new value goes in at the head.
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      ils_pkg::S_INS_WR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r - IW'(1);
      end
      ils_pkg::S_DEL_RD: begin
        mem_raddr = ptr_r + IW'(1);
        if (!del_more) cnt_nxt = cnt_r - CW'(1);
      end
      ils_pkg::S_DEL_WR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + IW'(1);
      end
      ils_pkg::S_SWP_A: begin
        tmp_nxt   = rdata_r;
        mem_raddr = ib_r;
      end
      ils_pkg::S_SWP_B: begin
        mem_we    = 1'b1;
        mem_waddr = ia_r;
      end
      ils_pkg::S_SWP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = ib_r;
        mem_wdata = tmp_r;
      end
      ils_pkg::S_DUMP_RD: mem_raddr = ptr_r;
      ils_pkg::S_DUMP_OUT: begin
        mem_raddr = ptr_r;
        if (out_free) begin
          out_load               = 1'b1;
          out_data_nxt.out_index = ptr_r;
          out_data_nxt.out_value = rdata_r;
          out_data_nxt.status    = ils_pkg::ST_OK;
          out_data_nxt.last      = dump_last;
          out_data_nxt.length    = cnt_r;
          ptr_nxt                = ptr_r + IW'(1);
        end
      end
      default: mem_raddr = ia_r;
    endcase

    if (out_load)      out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ils_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    op_r         <= op_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    val_r        <= val_nxt;
    tmp_r        <= tmp_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ils_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_idx_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_data_r.out_index} <= out_data_r.length))
    else $error("reported position lies beyond the stored length");

  a_busy_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ils_pkg::S_IDLE && state_nxt == ils_pkg::S_IDLE) |=> !out_valid_r || 
      $past(out_load))
    else $error("request finished without loading a result");

endmodule

/* verif/indexed_list_store_check.sv */
module indexed_list_store_check
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DATA_W-1:0] held_values [DEPTH];
  int                       held_len = 0;
  out_item_t                awaited_results [$];
  out_item_t                oldest;
  int                       fails = 0;
  int                       pending_n = 0;

  assign mismatch_count  = fails;
  assign results_pending = pending_n;

  // The reported length is always the occupancy after the request took effect.
  function automatic void await_result(logic [3:0] pos, logic signed [DATA_W-1:0] val,
                                       status_t st, logic fin);
    out_item_t r;
    r.out_index = pos;
    r.out_value = val;
    r.status    = st;
    r.last      = fin;
    r.length    = 5'(held_len);
    awaited_results.push_back(r);
  endfunction

  function automatic void remove_entry(int pos);
    for (int i = pos; i + 1 < held_len; i++) held_values[i] = held_values[i + 1];
    held_len--;
  endfunction

  function automatic void apply_request(in_item_t req);
    int                       a;
    int                       b;
    int                       n;
    logic signed [DATA_W-1:0] t;
    a = req.index_a;
    b = req.index_b;
    case (req.kind)
      K_READ: begin
        if (held_len == 0) await_result(4'd0, '0, ST_EMPTY, 1'b1);
        else if (a >= held_len) await_result(4'd0, '0, ST_BAD_INDEX, 1'b1);
        else await_result(req.index_a, held_values[a], ST_OK, 1'b1);
      end
      K_INS_FRONT: begin
        if (held_len >= DEPTH) begin
          await_result(4'd0, '0, ST_FULL, 1'b1);
        end else begin
          for (int i = held_len; i > 0; i--) held_values[i] = held_values[i - 1];
          held_values[0] = req.value;
          held_len++;
          await_result(4'd0, '0, ST_OK, 1'b1);
        end
      end
      K_INS_BACK: begin
        if (held_len >= DEPTH) begin
          await_result(4'd0, '0, ST_FULL, 1'b1);
        end else begin
          held_values[held_len] = req.value;
          held_len++;
          await_result(4'(held_len - 1), '0, ST_OK, 1'b1);
        end
      end
      K_DEL_FRONT: begin
        if (held_len == 0) begin
          await_result(4'd0, '0, ST_EMPTY, 1'b1);
        end else begin
          remove_entry(0);
          await_result(4'd0, '0, ST_OK, 1'b1);
        end
      end
      K_DEL_AT: begin
        if (held_len == 0) begin
          await_result(4'd0, '0, ST_EMPTY, 1'b1);
        end else if (a >= held_len) begin
          await_result(4'd0, '0, ST_BAD_INDEX, 1'b1);
        end else begin
          remove_entry(a);
          await_result(req.index_a, '0, ST_OK, 1'b1);
        end
      end
      K_SWAP: begin
        // A bad index wins over a swap of one position with itself.
        if (held_len == 0) begin
          await_result(4'd0, '0, ST_EMPTY, 1'b1);
        end else if (a >= held_len || b >= held_len) begin
          await_result(4'd0, '0, ST_BAD_INDEX, 1'b1);
        end else if (a == b) begin
          await_result(4'd0, '0, ST_SAME, 1'b1);
        end else begin
          t              = held_values[a];
          held_values[a] = held_values[b];
          held_values[b] = t;
          await_result(req.index_a, '0, ST_OK, 1'b1);
        end
      end
      K_DUMP: begin
        if (held_len == 0) begin
          await_result(4'd0, '0, ST_EMPTY, 1'b1);
        end else begin
          n = (held_len < DEPTH) ? held_len : DEPTH;
          for (int i = 0; i < n; i++) await_result(4'(i), held_values[i], ST_OK, i == n - 1);
        end
      end
      default: await_result(4'd0, '0, ST_BAD_INDEX, 1'b1);
    endcase
  endfunction

  // The request transfer is handled first so that its results queue behind older ones.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_len = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with none expected: index %0d value %0d status %0d",
                 out_data.out_index, out_data.out_value, out_data.status);
          fails++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data.out_index !== oldest.out_index) begin
            $error("out_index: expected %0d, got %0d", oldest.out_index, out_data.out_index);
            fails++;
          end
          if (out_data.out_value !== oldest.out_value) begin
            $error("out_value: expected %0d, got %0d", oldest.out_value, out_data.out_value);
            fails++;
          end
          if (out_data.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data.status);
            fails++;
          end
          if (out_data.last !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, out_data.last);
            fails++;
          end
          if (out_data.length !== oldest.length) begin
            $error("length: expected %0d, got %0d", oldest.length, out_data.length);
            fails++;
          end
        end
      end
    end
    pending_n = awaited_results.size();
  end

endmodule

/* verif/indexed_list_store_test.sv */
module indexed_list_store_test
  import ils_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FILL_GROW, FILL_MIX, FILL_DRAIN} fill_mode_t;

  localparam int SEGMENTS   = 12;
  localparam int SEG_ITEMS  = 25;
  localparam int LONG_HOLD  = 200;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatch_count;
  int        results_pending;

  bit quiet_tail        = 1'b0;
  bit sender_gaps       = 1'b1;
  bit long_hold_pending = 1'b0;
  int occupancy         = 0;

  indexed_list_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  indexed_list_store_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Holds a request until its transfer, then tracks how full the store should be.
  task automatic offer(input kind_t k, input logic [3:0] a, input logic [3:0] b,
                       input logic signed [DATA_W-1:0] v);
    in_item_t req;
    req.kind    = k;
    req.index_a = a;
    req.index_b = b;
    req.value   = v;
    if (!quiet_tail && sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (k)
      K_INS_FRONT, K_INS_BACK: if (occupancy < DEPTH) occupancy++;
      K_DEL_FRONT: if (occupancy > 0) occupancy--;
      K_DEL_AT: if (a < occupancy) occupancy--;
      default: ;
    endcase
  endtask

  function automatic kind_t draw_kind(fill_mode_t mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_GROW: begin
        if (r < 40) return K_INS_FRONT;
        if (r < 80) return K_INS_BACK;
      end
      FILL_DRAIN: begin
        if (r < 40) return K_DEL_FRONT;
        if (r < 80) return K_DEL_AT;
      end
      default: ;
    endcase
    return kind_t'($urandom_range(0, 6));
  endfunction

  // Mostly positions that hold an entry, sometimes anything the field allows.
  function automatic logic [3:0] draw_index();
    if (occupancy > 0 && $urandom_range(0, 4) != 0) return 4'($urandom_range(0, occupancy - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_random(fill_mode_t mode);
    kind_t      k;
    logic [3:0] a;
    logic [3:0] b;
    k = draw_kind(mode);
    a = draw_index();
    b = ($urandom_range(0, 6) == 0) ? a : draw_index();
    offer(k, a, b, draw_value());
  endtask

  initial begin : output_pacing
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    while (!quiet_tail) begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    out_stall <= 1'b0;
  end

  initial begin : stimulus
    fill_mode_t mode;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Each request kind on an empty store but insert front, then directed cases on a four-entry store.
    offer(K_READ, 4'd0, 4'd0, '0);
    offer(K_DEL_FRONT, 4'd0, 4'd0, '0);
    offer(K_DEL_AT, 4'd0, 4'd0, '0);
    offer(K_SWAP, 4'd0, 4'd1, '0);
    offer(K_DUMP, 4'd0, 4'd0, '0);
    offer(K_INS_BACK, 4'd0, 4'd0, 32'sh7FFF_FFFF);
    offer(K_INS_FRONT, 4'd0, 4'd0, 32'sh8000_0000);
    offer(K_INS_BACK, 4'd15, 4'd15, '0);
    offer(K_INS_FRONT, 4'd0, 4'd0, '1);
    offer(K_READ, 4'd0, 4'd0, '0);
    offer(K_READ, 4'd3, 4'd0, '0);
    offer(K_READ, 4'd4, 4'd0, '0);
    offer(K_READ, 4'd15, 4'd0, '0);
    offer(K_SWAP, 4'd2, 4'd2, '0);
    offer(K_SWAP, 4'd0, 4'd15, '0);
    offer(K_SWAP, 4'd15, 4'd15, '0);
    offer(K_SWAP, 4'd3, 4'd0, '0);
    offer(K_DUMP, 4'd0, 4'd0, '0);
    offer(K_DEL_AT, 4'd3, 4'd0, '0);
    offer(K_DEL_AT, 4'd5, 4'd0, '0);
    offer(K_DEL_AT, 4'd0, 4'd0, '0);
    offer(K_DEL_FRONT, 4'd0, 4'd0, '0);
    offer(K_READ, 4'd0, 4'd0, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0:       mode = FILL_GROW;
        2:       mode = FILL_DRAIN;
        default: mode = FILL_MIX;
      endcase
      if (seg == SEGMENTS - 1) quiet_tail = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) offer_random(mode);

      if (seg == 4) begin
        // The output side holds off while requests keep coming, so the input backs up.
        long_hold_pending = 1'b1;
        sender_gaps = 1'b0;
        for (int n = 0; n < 12; n++) offer_random(FILL_MIX);
        sender_gaps = 1'b1;
      end
      if (seg == 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    wait (results_pending == 0);
    repeat (4 * DEPTH) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
